### hw/rtl/tkf_pkg.sv
// shared word type, saturation helpers and the arctangent table of the tilt filter
package tkf_pkg;

    typedef logic signed [31:0] word_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TIME_STEP   = 2'd0,
        REG_ANGLE_NOISE = 2'd1,
        REG_BIAS_NOISE  = 2'd2,
        REG_MEAS_NOISE  = 2'd3
    } cfg_reg_t;

    localparam word_t WORD_MAX = 32'sh7FFFFFFF;
    localparam word_t WORD_MIN = 32'sh80000000;

    // pi and pi/2 in Q30, and 8*pi in Q30 for the gyro scale
    localparam logic [33:0]        PI_Q30      = 34'd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [34:0]        PI_Q30_X8   = 35'd26986075408;

    localparam int CORDIC_ITERS = 30;
    localparam int RATE_DIVISOR = 20700;

    function automatic word_t tkf_sat(input logic signed [33:0] v);
        word_t r;
        if (v > 34'sd2147483647) begin
            r = WORD_MAX;
        end else if (v < -34'sd2147483648) begin
            r = WORD_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic word_t tkf_add(input word_t a, input word_t b);
        logic signed [33:0] s;
        s = $signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b});
        return tkf_sat(s);
    endfunction

    function automatic word_t tkf_sub(input word_t a, input word_t b);
        logic signed [33:0] s;
        s = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
        return tkf_sat(s);
    endfunction

    // atan(2^-i) in Q30
    function automatic logic [29:0] tkf_atan(input logic [4:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000007;
            5'd28: r = 30'h00000003;
            5'd29: r = 30'h00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/tkf_mul.sv
// bit-serial signed fixed-point multiplier with rounding and saturation
module tkf_mul
    import tkf_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    output logic  done,
    output word_t result
);

    typedef enum logic [1:0] {MUL_IDLE, MUL_RUN, MUL_ROUND} mul_state_t;

    localparam logic [4:0]        LAST_STEP  = 5'd31;
    localparam logic signed [65:0] ROUND_HALF = 66'sd1 <<< (FRAC_BITS - 1);

    mul_state_t        state_reg;
    logic [4:0]        cnt_reg;
    logic [64:0]       prod_reg;
    word_t             a_reg;
    word_t             result_reg;
    logic              done_reg;
    logic signed [33:0] a_ext;
    logic signed [33:0] addend;
    logic signed [33:0] sum;
    logic signed [65:0] rounded;
    logic signed [65:0] shifted;

    always_comb begin
        a_ext = $signed({{2{a_reg[31]}}, a_reg});
        // the top multiplier bit carries negative weight
        if (!prod_reg[0]) begin
            addend = '0;
        end else if (cnt_reg == LAST_STEP) begin
            addend = -a_ext;
        end else begin
            addend = a_ext;
        end
        sum     = $signed({prod_reg[64], prod_reg[64:32]}) + addend;
        rounded = $signed({prod_reg[64], prod_reg}) + ROUND_HALF;
        shifted = rounded >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MUL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MUL_IDLE: begin
                    if (start) begin
                        a_reg     <= a;
                        prod_reg  <= {33'b0, b};
                        cnt_reg   <= '0;
                        state_reg <= MUL_RUN;
                    end
                end
                MUL_RUN: begin
                    prod_reg <= {sum, prod_reg[31:1]};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP) begin
                        state_reg <= MUL_ROUND;
                    end
                end
                MUL_ROUND: begin
                    if (shifted > 66'sd2147483647) begin
                        result_reg <= WORD_MAX;
                    end else if (shifted < -66'sd2147483648) begin
                        result_reg <= WORD_MIN;
                    end else begin
                        result_reg <= shifted[31:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= MUL_IDLE;
                end
                default: state_reg <= MUL_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hw/rtl/tkf_div.sv
// bit-serial restoring divider, rounded half away from zero, saturated to a word
module tkf_div
    import tkf_pkg::*;
#(
    parameter int NUM_W = 56
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [31:0]      den,
    input  logic             neg,
    output logic             done,
    output word_t            result
);

    typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_FINISH} div_state_t;

    localparam int            CW        = $clog2(NUM_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(NUM_W - 1);

    div_state_t       state_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NUM_W-1:0] acc_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      den_reg;
    logic             neg_reg;
    word_t            result_reg;
    logic             done_reg;
    logic [32:0]      shifted;
    logic             ge;
    logic             over;

    always_comb begin
        shifted = {rem_reg, acc_reg[NUM_W-1]};
        ge      = shifted >= {1'b0, den_reg};
        over    = |acc_reg[NUM_W-1:31];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DIV_IDLE: begin
                    if (start) begin
                        // half the divisor added up front gives the rounding
                        acc_reg   <= num + NUM_W'(den >> 1);
                        rem_reg   <= '0;
                        den_reg   <= den;
                        neg_reg   <= neg;
                        cnt_reg   <= '0;
                        state_reg <= DIV_RUN;
                    end
                end
                DIV_RUN: begin
                    rem_reg   <= ge ? 32'(shifted - {1'b0, den_reg}) : shifted[31:0];
                    acc_reg   <= {acc_reg[NUM_W-2:0], ge};
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP) begin
                        state_reg <= DIV_FINISH;
                    end
                end
                DIV_FINISH: begin
                    if (neg_reg) begin
                        result_reg <= over ? WORD_MIN : word_t'(32'd0 - acc_reg[31:0]);
                    end else begin
                        result_reg <= over ? WORD_MAX : word_t'(acc_reg[31:0]);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= DIV_IDLE;
                end
                default: state_reg <= DIV_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hw/rtl/tilt_kalman_filter_two_axis.sv
// two-axis tilt kalman filter: cordic tilt, serial multiply and divide, per-axis state
//
//  channel | direction | handshake             | content
//  s_      | in        | s_tvalid / s_tready   | tuser axis; tdata accel x/y/z, gyro x/y
//  m_      | out       | m_tvalid / m_tready   | tuser axis_out, degenerate; tdata angle, bias
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// one item at a time; each item runs three serial divides, NW = max(FRAC_BITS+32, 51) bits wide,
// and ten 32-step multiplies (the cordic runs beside the gyro scaling divide);
// a degenerate item skips the gain work
// an item for an axis beyond NUM_AXES returns zeros
// reset (aresetn low, synchronous) restores the control and configuration registers and every axis state at once
// a result waiting on m_tready holds the last step only; the next item is still taken
module tilt_kalman_filter_two_axis
    import tkf_pkg::*;
#(
    parameter int NUM_AXES  = 2,
    parameter int FRAC_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y
    input  logic [0:0]  s_tuser,   // axis
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // angle_estimate, bias_estimate, zero fill
    output logic [1:0]  m_tuser,   // axis_out, degenerate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DIV_NW = (FRAC_BITS + 32 > 51) ? FRAC_BITS + 32 : 51;

    localparam word_t       ONE_Q     = word_t'(32'(64'd1 << FRAC_BITS));
    localparam logic [23:0] TS_RESET  = 24'((2 * (64'd1 << FRAC_BITS) + 500) / 1000);
    localparam logic [30:0] APN_RESET = 31'((64'd1 << FRAC_BITS) / 1000);
    localparam logic [30:0] BPN_RESET = 31'((3 * (64'd1 << FRAC_BITS) + 500) / 1000);
    localparam logic [30:0] MN_RESET  = 31'((3 * (64'd1 << FRAC_BITS) + 5) / 10);
    localparam logic [31:0] RATE_DEN  = 32'(64'(RATE_DIVISOR) << (30 - FRAC_BITS));

    localparam logic signed [33:0] Z_HALF = 34'sd1 <<< (29 - FRAC_BITS);
    localparam int                 Z_SHIFT = 30 - FRAC_BITS;
    localparam logic signed [33:0] PI_F =
        $signed((PI_Q30 + (34'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_ITERS - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_RATE, ST_MEAS,
        ST_PM0, ST_PM1, ST_PM2, ST_PM3, ST_CHECK, ST_K0, ST_K1,
        ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_WRITE, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [23:0] time_step_reg;
    logic [30:0] angle_noise_reg;
    logic [30:0] bias_noise_reg;
    logic [30:0] meas_noise_reg;

    // per-axis filter state
    word_t angle_state_reg [0:NUM_AXES-1];
    word_t bias_state_reg  [0:NUM_AXES-1];
    word_t cov_aa_reg      [0:NUM_AXES-1];
    word_t cov_ab_reg      [0:NUM_AXES-1];
    word_t cov_ba_reg      [0:NUM_AXES-1];
    word_t cov_bb_reg      [0:NUM_AXES-1];

    // latched item
    logic        ax_reg;
    logic [15:0] accel_x_reg;
    logic [15:0] accel_y_reg;
    logic [15:0] accel_z_reg;
    logic [15:0] gyro_x_reg;
    logic [15:0] gyro_y_reg;

    // working values
    word_t ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    word_t rate_reg, meas_reg, pred_reg, err_reg, e_reg;
    word_t pd00_reg, pd11_reg, k0_reg, k1_reg;
    logic  degen_reg;

    // serial unit handshakes
    logic              mul_start_reg;
    word_t             mul_a_reg, mul_b_reg;
    logic              mul_done;
    word_t             mul_res;
    logic              div_start_reg;
    logic [DIV_NW-1:0] div_num_reg;
    logic [31:0]       div_den_reg;
    logic              div_neg_reg;
    logic              div_done;
    word_t             div_res;

    // cordic
    logic              cordic_start_reg;
    logic              c_busy_reg;
    logic              c_zero_reg;
    logic [4:0]        c_cnt_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [33:0] cz_reg;

    // output stage
    logic        m_tvalid_reg;
    logic        axis_out_reg;
    logic        degen_out_reg;
    logic [26:0] angle_out_reg;
    word_t       bias_out_reg;

    // combinational helpers
    logic signed [15:0] raw_rate;
    logic [16:0]        raw_mag;
    logic [51:0]        rate_prod;
    logic signed [16:0] x17, y17;
    logic signed [35:0] x_sc, y_sc;
    logic signed [35:0] xs, ys;
    logic signed [33:0] tab;
    logic signed [33:0] zr;
    word_t              meas_calc;
    logic signed [33:0] pd00_sum;
    word_t              e_calc;
    logic signed [33:0] ang_ext;
    logic signed [33:0] ang_clamp;
    logic               skip_axis;

    word_t dt_word, bpn_word, mn_word;

    function automatic logic [DIV_NW-1:0] gain_num(input word_t p);
        logic [31:0] mag;
        mag = p[31] ? 32'(-p) : 32'(p);
        return DIV_NW'(mag) << FRAC_BITS;
    endfunction

    always_comb begin
        dt_word  = word_t'({8'b0, time_step_reg});
        bpn_word = word_t'({1'b0, bias_noise_reg});
        mn_word  = word_t'({1'b0, meas_noise_reg});

        raw_rate  = ax_reg ? $signed(gyro_y_reg) : $signed(gyro_x_reg);
        raw_mag   = raw_rate[15] ? 17'(-$signed({raw_rate[15], raw_rate}))
                                 : {1'b0, raw_rate};
        rate_prod = raw_mag * PI_Q30_X8;

        // pitch uses minus accel x
        y17  = ax_reg ? -$signed({accel_x_reg[15], accel_x_reg})
                      : $signed({accel_y_reg[15], accel_y_reg});
        x17  = $signed({accel_z_reg[15], accel_z_reg});
        x_sc = x17 <<< 14;
        y_sc = y17 <<< 14;

        xs  = cx_reg >>> c_cnt_reg;
        ys  = cy_reg >>> c_cnt_reg;
        tab = $signed({4'b0, tkf_atan(c_cnt_reg)});

        zr = (cz_reg + Z_HALF) >>> Z_SHIFT;
        if (c_zero_reg) begin
            meas_calc = '0;
        end else if (zr > PI_F) begin
            meas_calc = PI_F[31:0];
        end else if (zr < -PI_F) begin
            meas_calc = 32'(-PI_F);
        end else begin
            meas_calc = zr[31:0];
        end

        pd00_sum = $signed({3'b0, angle_noise_reg})
                 - $signed({{2{p01_reg[31]}}, p01_reg})
                 - $signed({{2{p10_reg[31]}}, p10_reg});
        e_calc   = tkf_add(mn_word, p00_reg);

        ang_ext = $signed({{2{ang_reg[31]}}, ang_reg});
        if (ang_ext > PI_F) begin
            ang_clamp = PI_F;
        end else if (ang_ext < -PI_F) begin
            ang_clamp = -PI_F;
        end else begin
            ang_clamp = ang_ext;
        end

        skip_axis = int'(ax_reg) >= NUM_AXES;
    end

    // iterative cordic in vectoring mode, one rotation a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_busy_reg <= 1'b0;
        end else if (cordic_start_reg) begin
            c_zero_reg <= (x17 == 17'sd0) && (y17 == 17'sd0);
            c_cnt_reg  <= '0;
            c_busy_reg <= 1'b1;
            if (x17 < 0) begin
                if (y17 >= 0) begin
                    cx_reg <= y_sc;
                    cy_reg <= -x_sc;
                    cz_reg <= HALF_PI_Q30;
                end else begin
                    cx_reg <= -y_sc;
                    cy_reg <= x_sc;
                    cz_reg <= -HALF_PI_Q30;
                end
            end else begin
                cx_reg <= x_sc;
                cy_reg <= y_sc;
                cz_reg <= '0;
            end
        end else if (c_busy_reg) begin
            if (cy_reg >= 0) begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + tab;
            end else begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - tab;
            end
            c_cnt_reg <= c_cnt_reg + 1'b1;
            if (c_cnt_reg == CORDIC_LAST) begin
                c_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            mul_start_reg    <= 1'b0;
            div_start_reg    <= 1'b0;
            cordic_start_reg <= 1'b0;
            time_step_reg    <= TS_RESET;
            angle_noise_reg  <= APN_RESET;
            bias_noise_reg   <= BPN_RESET;
            meas_noise_reg   <= MN_RESET;
            for (int i = 0; i < NUM_AXES; i++) begin
                angle_state_reg[i] <= '0;
                bias_state_reg[i]  <= '0;
                cov_aa_reg[i]      <= ONE_Q;
                cov_ab_reg[i]      <= '0;
                cov_ba_reg[i]      <= '0;
                cov_bb_reg[i]      <= ONE_Q;
            end
        end else begin
            mul_start_reg    <= 1'b0;
            div_start_reg    <= 1'b0;
            cordic_start_reg <= 1'b0;
            // the output step sets the flag itself
            if (m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_TIME_STEP:   time_step_reg   <= cfg_data[23:0];
                    REG_ANGLE_NOISE: angle_noise_reg <= cfg_data[30:0];
                    REG_BIAS_NOISE:  bias_noise_reg  <= cfg_data[30:0];
                    REG_MEAS_NOISE:  meas_noise_reg  <= cfg_data[30:0];
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ax_reg      <= s_tuser[0];
                        accel_x_reg <= s_tdata[15:0];
                        accel_y_reg <= s_tdata[31:16];
                        accel_z_reg <= s_tdata[47:32];
                        gyro_x_reg  <= s_tdata[63:48];
                        gyro_y_reg  <= s_tdata[79:64];
                        state_reg   <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (skip_axis) begin
                        ang_reg   <= '0;
                        bias_reg  <= '0;
                        degen_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end else begin
                        ang_reg          <= angle_state_reg[ax_reg];
                        bias_reg         <= bias_state_reg[ax_reg];
                        p00_reg          <= cov_aa_reg[ax_reg];
                        p01_reg          <= cov_ab_reg[ax_reg];
                        p10_reg          <= cov_ba_reg[ax_reg];
                        p11_reg          <= cov_bb_reg[ax_reg];
                        div_num_reg      <= DIV_NW'(rate_prod);
                        div_den_reg      <= RATE_DEN;
                        div_neg_reg      <= raw_rate[15];
                        div_start_reg    <= 1'b1;
                        cordic_start_reg <= 1'b1;
                        state_reg        <= ST_RATE;
                    end
                end
                ST_RATE: begin
                    if (div_done) begin
                        rate_reg  <= div_res;
                        state_reg <= ST_MEAS;
                    end
                end
                ST_MEAS: begin
                    if (!c_busy_reg) begin
                        meas_reg      <= meas_calc;
                        pd00_reg      <= tkf_sat(pd00_sum);
                        pd11_reg      <= tkf_sub('0, p11_reg);
                        mul_a_reg     <= tkf_sub(rate_reg, bias_reg);
                        mul_b_reg     <= dt_word;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_PM0;
                    end
                end
                ST_PM0: begin
                    if (mul_done) begin
                        pred_reg      <= tkf_add(ang_reg, mul_res);
                        mul_a_reg     <= pd00_reg;
                        mul_b_reg     <= dt_word;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_PM1;
                    end
                end
                ST_PM1: begin
                    if (mul_done) begin
                        p00_reg       <= tkf_add(p00_reg, mul_res);
                        mul_a_reg     <= pd11_reg;
                        mul_b_reg     <= dt_word;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_PM2;
                    end
                end
                ST_PM2: begin
                    if (mul_done) begin
                        p01_reg       <= tkf_add(p01_reg, mul_res);
                        p10_reg       <= tkf_add(p10_reg, mul_res);
                        mul_a_reg     <= bpn_word;
                        mul_b_reg     <= dt_word;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_PM3;
                    end
                end
                ST_PM3: begin
                    if (mul_done) begin
                        p11_reg   <= tkf_add(p11_reg, mul_res);
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    err_reg <= tkf_sub(meas_reg, pred_reg);
                    e_reg   <= e_calc;
                    if (e_calc <= 0) begin
                        // innovation variance not positive: keep the prediction
                        degen_reg <= 1'b1;
                        ang_reg   <= pred_reg;
                        state_reg <= ST_WRITE;
                    end else begin
                        degen_reg     <= 1'b0;
                        div_num_reg   <= gain_num(p00_reg);
                        div_den_reg   <= 32'(e_calc);
                        div_neg_reg   <= p00_reg[31];
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_K0;
                    end
                end
                ST_K0: begin
                    if (div_done) begin
                        k0_reg        <= div_res;
                        div_num_reg   <= gain_num(p10_reg);
                        div_den_reg   <= 32'(e_reg);
                        div_neg_reg   <= p10_reg[31];
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_K1;
                    end
                end
                ST_K1: begin
                    if (div_done) begin
                        k1_reg        <= div_res;
                        mul_a_reg     <= div_res;
                        mul_b_reg     <= p00_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_C0;
                    end
                end
                // rows are updated in an order that keeps the predicted p00 and p01
                ST_C0: begin
                    if (mul_done) begin
                        p10_reg       <= tkf_sub(p10_reg, mul_res);
                        mul_a_reg     <= k1_reg;
                        mul_b_reg     <= p01_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_C1;
                    end
                end
                ST_C1: begin
                    if (mul_done) begin
                        p11_reg       <= tkf_sub(p11_reg, mul_res);
                        mul_a_reg     <= k0_reg;
                        mul_b_reg     <= p00_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_C2;
                    end
                end
                ST_C2: begin
                    if (mul_done) begin
                        p00_reg       <= tkf_sub(p00_reg, mul_res);
                        mul_a_reg     <= k0_reg;
                        mul_b_reg     <= p01_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_C3;
                    end
                end
                ST_C3: begin
                    if (mul_done) begin
                        p01_reg       <= tkf_sub(p01_reg, mul_res);
                        mul_a_reg     <= k0_reg;
                        mul_b_reg     <= err_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_C4;
                    end
                end
                ST_C4: begin
                    if (mul_done) begin
                        ang_reg       <= tkf_add(pred_reg, mul_res);
                        mul_a_reg     <= k1_reg;
                        mul_b_reg     <= err_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_C5;
                    end
                end
                ST_C5: begin
                    if (mul_done) begin
                        bias_reg  <= tkf_add(bias_reg, mul_res);
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    angle_state_reg[ax_reg] <= ang_reg;
                    bias_state_reg[ax_reg]  <= bias_reg;
                    cov_aa_reg[ax_reg]      <= p00_reg;
                    cov_ab_reg[ax_reg]      <= p01_reg;
                    cov_ba_reg[ax_reg]      <= p10_reg;
                    cov_bb_reg[ax_reg]      <= p11_reg;
                    state_reg               <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        axis_out_reg  <= ax_reg;
                        degen_out_reg <= degen_reg;
                        angle_out_reg <= ang_clamp[26:0];
                        bias_out_reg  <= bias_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    tkf_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start_reg),
        .a      (mul_a_reg),
        .b      (mul_b_reg),
        .done   (mul_done),
        .result (mul_res)
    );

    tkf_div #(
        .NUM_W(DIV_NW)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start_reg),
        .num    (div_num_reg),
        .den    (div_den_reg),
        .neg    (div_neg_reg),
        .done   (div_done),
        .result (div_res)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'b0, bias_out_reg, angle_out_reg};
    assign m_tuser   = {degen_out_reg, axis_out_reg};

endmodule
